// ===== design/mra_pkg.sv =====
// Shared constants and controller/datapath interface types for the region aligner.
// Depends on nothing; every other design file imports it.
package mra_pkg;

  localparam int ADDR_WIDTH      = 32;
  localparam int LOG2_WIDTH      = 5;
  localparam int SUM_WIDTH       = 33;
  localparam int IN_DATA_WIDTH   = 64;
  localparam int OUT_DATA_WIDTH  = 72;

  localparam logic [LOG2_WIDTH-1:0] MIN_REGION_LOG2 = 5'd5;
  localparam logic [LOG2_WIDTH-1:0] LIMIT_LOG2      = 5'd31;
  localparam logic [31:0]           MIN_REGION      = 32'd32;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } mra_cmd_t;

  typedef struct packed {
    logic fits;
    logic at_limit;
  } mra_status_t;

  typedef struct packed {
    logic [31:0] region_base;
    logic [30:0] region_bytes;
    logic [4:0]  size_field;
    logic        too_large;
  } mra_result_t;

endpackage

// ===== design/mra_ctrl.sv =====
// Sequencing state machine of the region aligner: handshakes and datapath commands.
// Depends on mra_pkg.
module mra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mra_pkg::mra_status_t status,
  output mra_pkg::mra_cmd_t    cmd
);
  import mra_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   finished;

  assign finished = status.at_limit | status.fits;
  assign in_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finished) begin
          // The result waits here until the output register is free.
          if (!out_valid || out_ready) begin
            cmd.emit   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/mra_datapath.sv =====
// Datapath of the region aligner: operand registers, size exponent and result register.
// Depends on mra_pkg.
module mra_datapath (
  input  logic                 clk,
  input  mra_pkg::mra_cmd_t     cmd,
  input  logic [31:0]          block_start,
  input  logic [31:0]          block_length,
  output mra_pkg::mra_status_t  status,
  output mra_pkg::mra_result_t  result
);
  import mra_pkg::*;

  logic [ADDR_WIDTH-1:0] start;
  logic [31:0]           len;
  logic [LOG2_WIDTH-1:0] lg;
  logic [SUM_WIDTH-1:0]  pow;
  logic [SUM_WIDTH-1:0]  mask;
  logic [ADDR_WIDTH-1:0] slack;
  logic [SUM_WIDTH-1:0]  need;
  logic [ADDR_WIDTH-1:0] base;

  // Candidate region is 2^lg bytes; it covers the block when the length
  // plus the slack below the aligned base is no larger than the region.
  assign pow   = SUM_WIDTH'(1) << lg;
  assign mask  = pow - SUM_WIDTH'(1);
  assign slack = start & mask[ADDR_WIDTH-1:0];
  assign base  = start & ~mask[ADDR_WIDTH-1:0];
  assign need  = SUM_WIDTH'(len) + SUM_WIDTH'(slack);

  assign status.fits     = (need <= pow);
  assign status.at_limit = (lg >= LIMIT_LOG2);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start <= block_start[ADDR_WIDTH-1:0];
      len   <= (block_length < MIN_REGION) ? MIN_REGION : block_length;
      lg    <= MIN_REGION_LOG2;
    end else if (cmd.step) begin
      lg <= lg + LOG2_WIDTH'(1);
    end
    if (cmd.emit) begin
      if (status.at_limit) begin
        result <= '{region_base: '0, region_bytes: '0, size_field: '0, too_large: 1'b1};
      end else begin
        result.region_base  <= 32'(base);
        result.region_bytes <= pow[30:0];
        result.size_field   <= lg - LOG2_WIDTH'(1);
        result.too_large    <= 1'b0;
      end
    end
  end

endmodule

// ===== design/mpu_region_aligner.sv =====
// Top level of the protection region aligner: joins controller and datapath.
// Depends on mra_pkg, mra_ctrl and mra_datapath.
//
// For each input beat (block start address and byte length) the block returns one output
// beat with the smallest power-of-two region, of at least 32 bytes and aligned to its own
// size, that covers the whole block, together with the size field log2(size) - 1. Lengths
// below 32 are treated as 32. When the needed region would reach 2^31 bytes, too_large is
// set on tuser and all tdata fields are zero. The search tries region sizes one exponent at
// a time from 2^5 upwards, one add and compare per clock, so a beat occupies the block for
// a capture step and then one search step per exponent tried, up to the final exponent
// (the result exponent, or 31 on overflow). One item is in work at a time; the output
// register lets a new beat be accepted while the previous result still waits to be
// taken, and a finished search holds until that register is free.
module mpu_region_aligner (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0: block_start[31:0], block_length[63:32].
  input  logic [mra_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // Fields from bit 0: region_base[31:0], region_bytes[62:32], size_field[67:63],
  // zero padding[71:68].
  output logic [mra_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  // Fields from bit 0: too_large[0].
  output logic                               m_tuser
);
  import mra_pkg::*;

  mra_cmd_t    cmd;
  mra_status_t status;
  mra_result_t result;

  mra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mra_datapath u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .block_start  (s_tdata[31:0]),
    .block_length (s_tdata[63:32]),
    .status       (status),
    .result       (result)
  );

  // Output beat packing; the top four bits are padding.
  assign m_tdata = {4'b0000, result.size_field, result.region_bytes, result.region_base};
  assign m_tuser = result.too_large;

  // A region that is not too large is a single power of two with its base aligned to it.
  logic [31:0] bytes_ext;
  assign bytes_ext = {1'b0, result.region_bytes};

  // Once a beat is accepted the block is busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted again straight after an accepted beat");

  // An oversized result carries zero fields.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("too_large result with non-zero fields");

  // A valid region is a power of two with an aligned base and a matching size field.
  a_region_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |->
      ($onehot(bytes_ext) && ((result.region_base & (bytes_ext - 32'd1)) == 32'd0) &&
       (bytes_ext == (32'd2 << result.size_field)) && (bytes_ext >= MIN_REGION)))
    else $error("region is not an aligned power of two of at least 32 bytes");

endmodule
